### src/host_power_sequencer_top_defines.svh
// assertion macros shared by the host power sequencer files
`ifndef HOST_POWER_SEQUENCER_TOP_DEFINES_SVH
`define HOST_POWER_SEQUENCER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// condition must hold at every edge out of reset
`define HPS_ASSERT_HOLD(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// trigger at one edge implies result at the next edge
`define HPS_ASSERT_NEXT(lbl, clk, rst_n, trig, res, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) else $error(msg);
`else
`define HPS_ASSERT_HOLD(lbl, clk, rst_n, cond, msg)
`define HPS_ASSERT_NEXT(lbl, clk, rst_n, trig, res, msg)
`endif

`endif

### src/hps_pkg.sv
// types, codes and defaults of the host power sequencer
package hps_pkg;

    localparam int SEC_DIVIDE_DEF  = 200;
    localparam int FAST_DIVIDE_DEF = 4;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    // sequencer states
    localparam logic [3:0] ST_WAKE_INIT       = 4'd0;
    localparam logic [3:0] ST_WAKE_WAIT_PRESS = 4'd1;
    localparam logic [3:0] ST_WAKE_WAIT_REL   = 4'd2;
    localparam logic [3:0] ST_NORMAL          = 4'd3;
    localparam logic [3:0] ST_NORMAL_WAIT_REL = 4'd4;
    localparam logic [3:0] ST_SOFT_PULSE      = 4'd5;
    localparam logic [3:0] ST_WAIT_HOST_OFF   = 4'd6;
    localparam logic [3:0] ST_HARD_OFF        = 4'd7;
    localparam logic [3:0] ST_SLEEP           = 4'd8;

    // power-up reasons
    localparam logic [2:0] REASON_NONE    = 3'd0;
    localparam logic [2:0] REASON_ALARM   = 3'd1;
    localparam logic [2:0] REASON_BUTTON  = 3'd2;
    localparam logic [2:0] REASON_USB     = 3'd3;
    localparam logic [2:0] REASON_RESTART = 3'd4;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_RESTART_ENABLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOST_OFF_TMO   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_PRESS    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_HARD_PRESS     = 2'd3;

    localparam logic [15:0] HOST_OFF_TMO_DEF = 16'd60;
    localparam logic [7:0]  SHORT_PRESS_DEF  = 8'd3;
    localparam logic [9:0]  HARD_PRESS_DEF   = 10'd425;

    typedef struct packed {
        logic        restart_enable;
        logic [15:0] host_off_timeout_s;
        logic [7:0]  short_press_ticks;
        logic [9:0]  hard_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic       base_tick;
        logic       alarm_seen;
        logic       button_held;
        logic       button_pressed;
        logic       batt_low;
        logic       batt_restart_ok;
        logic       host_rail_good;
        logic       host_rail_prev;
        logic       usb_power_ok;
        logic       delay_write;
        logic [7:0] delay_seconds;
    } item_t;

    typedef struct packed {
        logic [3:0] seq_state;
        logic       power_on;
        logic       boost_on;
        logic       bypass_on;
        logic       host_button_drive;
        logic [2:0] power_up_reason;
        logic       sleep_request;
        logic       fast_tick;
        logic       sec_tick;
        logic       button_eval;
    } result_t;

endpackage

### src/hps_core.sv
// sequencer state, tick dividers and the single-pass next-state logic
`include "host_power_sequencer_top_defines.svh"

module hps_core #(
    parameter int SEC_DIVIDE  = hps_pkg::SEC_DIVIDE_DEF,
    parameter int FAST_DIVIDE = hps_pkg::FAST_DIVIDE_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  hps_pkg::item_t  item,
    input  hps_pkg::cfg_t   cfg,
    output hps_pkg::result_t result
);
    import hps_pkg::*;

    localparam int FD_W = (FAST_DIVIDE > 1) ? $clog2(FAST_DIVIDE) : 1;
    localparam logic [FD_W-1:0] FD_LAST = FD_W'(FAST_DIVIDE - 1);
    localparam logic [7:0]      SEC_RELOAD = 8'(SEC_DIVIDE);

    logic [3:0]      st_reg, st_next;
    logic [FD_W-1:0] fd_reg, fd_next;
    logic [7:0]      sd_reg, sd_next;
    logic [15:0]     cnt_reg, cnt_next;
    logic [7:0]      sdc_reg, sdc_next;
    logic            pon_reg, pon_next;
    logic            boost_reg, boost_next;
    logic            bypass_reg, bypass_next;
    logic            btn_reg, btn_next;
    logic [2:0]      reason_reg, reason_next;

    logic        fast, sec, beval, sleep_req;
    logic        do_pu;
    logic [2:0]  pu_reason;
    logic [7:0]  sd_dec;
    logic [7:0]  sdc_dec;
    logic [15:0] cnt_dec;

    always_comb begin
        st_next     = st_reg;
        fd_next     = fd_reg;
        sd_next     = sd_reg;
        cnt_next    = cnt_reg;
        pon_next    = pon_reg;
        boost_next  = boost_reg;
        bypass_next = bypass_reg;
        btn_next    = btn_reg;
        reason_next = reason_reg;
        fast        = 1'b0;
        sec         = 1'b0;
        beval       = 1'b0;
        sleep_req   = 1'b0;
        do_pu       = 1'b0;
        pu_reason   = REASON_NONE;
        sd_dec      = sd_reg - 8'd1;
        cnt_dec     = cnt_reg - 16'd1;

        // dividers first
        if (item.base_tick) begin
            fd_next = (fd_reg == FD_LAST) ? '0 : fd_reg + FD_W'(1);
            fast    = (fd_next == '0);
            if (sd_dec == 8'd0) begin
                sd_next = SEC_RELOAD;
                sec     = 1'b1;
            end else begin
                sd_next = sd_dec;
            end
        end

        // delayed power-down load, any state
        sdc_next = item.delay_write ? item.delay_seconds : sdc_reg;
        sdc_dec  = sdc_next - 8'd1;

        case (st_reg)
            ST_WAKE_INIT: begin
                if (item.alarm_seen) begin
                    if (item.batt_low) begin
                        st_next = ST_SLEEP;
                    end else begin
                        do_pu     = 1'b1;
                        pu_reason = REASON_ALARM;
                    end
                end else if (item.button_held) begin
                    st_next = item.batt_low ? ST_WAKE_WAIT_REL : ST_WAKE_WAIT_PRESS;
                end else if (!item.host_rail_prev && item.host_rail_good) begin
                    do_pu     = 1'b1;
                    pu_reason = REASON_USB;
                end else if (cfg.restart_enable && item.batt_restart_ok) begin
                    do_pu     = 1'b1;
                    pu_reason = REASON_RESTART;
                end else begin
                    st_next = ST_SLEEP;
                end
            end
            ST_WAKE_WAIT_PRESS: begin
                if (fast) begin
                    beval = 1'b1;
                    if (item.button_held) begin
                        if (item.button_pressed) begin
                            do_pu     = 1'b1;
                            pu_reason = REASON_BUTTON;
                        end
                    end else begin
                        st_next = ST_SLEEP;
                    end
                end
                // alarm wins over anything the button did
                if (item.alarm_seen) begin
                    do_pu     = 1'b1;
                    pu_reason = REASON_ALARM;
                end
            end
            ST_WAKE_WAIT_REL, ST_NORMAL_WAIT_REL: begin
                if (fast) begin
                    beval = 1'b1;
                    if (!item.button_held) begin
                        st_next = ST_SLEEP;
                    end
                end
            end
            ST_NORMAL: begin
                if (item.host_rail_prev && !item.host_rail_good) begin
                    st_next     = ST_SLEEP;
                    pon_next    = 1'b0;
                    boost_next  = 1'b0;
                    bypass_next = 1'b0;
                end else if (fast) begin
                    beval = 1'b1;
                    if (item.button_pressed) begin
                        st_next  = ST_SOFT_PULSE;
                        btn_next = 1'b1;
                        cnt_next = {8'd0, cfg.short_press_ticks};
                    end
                end
                // countdown expiry overrides a pulse started in this step
                if (sec && (sdc_next != 8'd0)) begin
                    sdc_next = sdc_dec;
                    if (sdc_dec == 8'd0) begin
                        st_next     = ST_SLEEP;
                        pon_next    = 1'b0;
                        boost_next  = 1'b0;
                        bypass_next = 1'b0;
                    end
                end
            end
            ST_SOFT_PULSE: begin
                if (fast) begin
                    cnt_next = cnt_dec;
                    if (cnt_dec == 16'd0) begin
                        btn_next = 1'b0;
                        st_next  = ST_WAIT_HOST_OFF;
                        cnt_next = cfg.host_off_timeout_s;
                    end
                end
            end
            ST_WAIT_HOST_OFF: begin
                if (sec) begin
                    cnt_next = cnt_dec;
                end
                if (!item.host_rail_good) begin
                    st_next     = ST_NORMAL_WAIT_REL;
                    pon_next    = 1'b0;
                    boost_next  = 1'b0;
                    bypass_next = 1'b0;
                end else if (cnt_next == 16'd0) begin
                    btn_next = 1'b1;
                    st_next  = ST_HARD_OFF;
                    cnt_next = {6'd0, cfg.hard_press_ticks};
                end
            end
            ST_HARD_OFF: begin
                if (fast) begin
                    cnt_next = cnt_dec;
                    if (cnt_dec == 16'd0) begin
                        btn_next    = 1'b0;
                        st_next     = ST_NORMAL_WAIT_REL;
                        pon_next    = 1'b0;
                        boost_next  = 1'b0;
                        bypass_next = 1'b0;
                    end
                end
            end
            ST_SLEEP: begin
                sleep_req = 1'b1;
                st_next   = ST_WAKE_INIT;
                sd_next   = SEC_RELOAD;
            end
            default: begin
                st_next = ST_SLEEP;
            end
        endcase

        // power up effects
        if (do_pu) begin
            reason_next = pu_reason;
            st_next     = ST_NORMAL;
            sdc_next    = 8'd0;
            cnt_next    = 16'd0;
            pon_next    = 1'b1;
            sd_next     = SEC_RELOAD;
            if (item.usb_power_ok) begin
                bypass_next = 1'b1;
            end else begin
                boost_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_WAKE_INIT;
            fd_reg     <= '0;
            sd_reg     <= SEC_RELOAD;
            cnt_reg    <= 16'd0;
            sdc_reg    <= 8'd0;
            pon_reg    <= 1'b0;
            boost_reg  <= 1'b0;
            bypass_reg <= 1'b0;
            btn_reg    <= 1'b0;
            reason_reg <= REASON_NONE;
        end else if (step_en) begin
            st_reg     <= st_next;
            fd_reg     <= fd_next;
            sd_reg     <= sd_next;
            cnt_reg    <= cnt_next;
            sdc_reg    <= sdc_next;
            pon_reg    <= pon_next;
            boost_reg  <= boost_next;
            bypass_reg <= bypass_next;
            btn_reg    <= btn_next;
            reason_reg <= reason_next;
        end
    end

    always_comb begin
        result.seq_state         = st_next;
        result.power_on          = pon_next;
        result.boost_on          = boost_next;
        result.bypass_on         = bypass_next;
        result.host_button_drive = btn_next;
        result.power_up_reason   = reason_next;
        result.sleep_request     = sleep_req;
        result.fast_tick         = fast;
        result.sec_tick          = sec;
        result.button_eval       = beval;
    end

    // power is on exactly when one converter path drives it
    `HPS_ASSERT_HOLD(a_power_path, aclk, aresetn, ($onehot0({boost_reg, bypass_reg}) && (pon_reg == (boost_reg || bypass_reg))), "power flags inconsistent")
    // only defined states are ever stored
    `HPS_ASSERT_HOLD(a_state_range, aclk, aresetn, (st_reg <= ST_SLEEP), "sequencer left defined states")
    // second divider reloads before it could hold zero
    `HPS_ASSERT_HOLD(a_sec_div_range, aclk, aresetn, ((sd_reg != 8'd0) && (sd_reg <= SEC_RELOAD)), "second divider out of range")

endmodule

### src/host_power_sequencer_top.sv
// top level of the host power sequencer: stream ports, config registers, pipeline
// Host power sequencer. Every transfer on the s_ side is one evaluation step of a
// nine-state power sequencer (wake decision, power-up with boost or USB bypass,
// soft shutdown pulse, host-off wait with timeout, forced long press, sleep); every
// step yields exactly one transfer on the m_ side with the state after the step, the
// power flags, the power-up reason and the tick flags. One step is accepted per clock
// unless m_ stalls; a step sits in the input register, then goes through the next-state
// pass into the result register. The per-step rate is set by that single registered
// next-state pass, which carries the sequencer state from one step to the next.
// The result register lets a new step enter while the previous result still waits.
// Configuration writes on cfg_wr_en take effect at once and belong to idle periods.
// There is no clearing pass after reset.
`include "host_power_sequencer_top_defines.svh"

module host_power_sequencer_top #(
    parameter int SEC_DIVIDE  = hps_pkg::SEC_DIVIDE_DEF,
    parameter int FAST_DIVIDE = hps_pkg::FAST_DIVIDE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // step input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // from bit 0: base_tick, alarm_seen, button_held, button_pressed, batt_low,
    // batt_restart_ok, host_rail_good, host_rail_prev, usb_power_ok, delay_write,
    // delay_seconds[7:0], zero fill
    input  logic [hps_pkg::IN_TDATA_W-1:0]     s_tdata,
    // step result
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // from bit 0: seq_state[3:0], power_on, boost_on, bypass_on, host_button_drive,
    // power_up_reason[2:0], sleep_request, fast_tick, sec_tick, button_eval, zero fill
    output logic [hps_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // config write port
    input  logic                               cfg_wr_en,
    input  logic [hps_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [hps_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import hps_pkg::*;

    cfg_t    cfg_reg;
    item_t   in_item_reg;
    logic    in_vld_reg;
    result_t out_res_reg;
    logic    out_vld_reg;
    result_t core_res;
    logic    advance;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.restart_enable     <= 1'b0;
            cfg_reg.host_off_timeout_s <= HOST_OFF_TMO_DEF;
            cfg_reg.short_press_ticks  <= SHORT_PRESS_DEF;
            cfg_reg.hard_press_ticks   <= HARD_PRESS_DEF;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_RESTART_ENABLE: cfg_reg.restart_enable     <= cfg_wdata[0];
                CFG_HOST_OFF_TMO:   cfg_reg.host_off_timeout_s <= cfg_wdata;
                CFG_SHORT_PRESS:    cfg_reg.short_press_ticks  <= cfg_wdata[7:0];
                CFG_HARD_PRESS:     cfg_reg.hard_press_ticks   <= cfg_wdata[9:0];
                default:            cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    // step moves into the result register when that register is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.base_tick       <= s_tdata[0];
            in_item_reg.alarm_seen      <= s_tdata[1];
            in_item_reg.button_held     <= s_tdata[2];
            in_item_reg.button_pressed  <= s_tdata[3];
            in_item_reg.batt_low        <= s_tdata[4];
            in_item_reg.batt_restart_ok <= s_tdata[5];
            in_item_reg.host_rail_good  <= s_tdata[6];
            in_item_reg.host_rail_prev  <= s_tdata[7];
            in_item_reg.usb_power_ok    <= s_tdata[8];
            in_item_reg.delay_write     <= s_tdata[9];
            in_item_reg.delay_seconds   <= s_tdata[17:10];
        end
    end

    // sequencer state and next-state pass
    hps_core #(
        .SEC_DIVIDE  (SEC_DIVIDE),
        .FAST_DIVIDE (FAST_DIVIDE)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (core_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0,
                       out_res_reg.button_eval,
                       out_res_reg.sec_tick,
                       out_res_reg.fast_tick,
                       out_res_reg.sleep_request,
                       out_res_reg.power_up_reason,
                       out_res_reg.host_button_drive,
                       out_res_reg.bypass_on,
                       out_res_reg.boost_on,
                       out_res_reg.power_on,
                       out_res_reg.seq_state};

    // a step that advances always leaves a result behind
    `HPS_ASSERT_NEXT(a_advance_result, aclk, aresetn, advance, out_vld_reg, "advanced step produced no result")
    // a waiting step with a blocked result stays in the input register
    `HPS_ASSERT_NEXT(a_hold_step, aclk, aresetn, (in_vld_reg && out_vld_reg && !m_tready), in_vld_reg, "waiting step lost")
    // a sleep result always returns the sequencer to wake-init
    `HPS_ASSERT_HOLD(a_sleep_state, aclk, aresetn, (!out_vld_reg || !out_res_reg.sleep_request || (out_res_reg.seq_state == ST_WAKE_INIT)), "sleep result with wrong state")

endmodule

### verif/hps_status_checker.sv
`timescale 1ns / 100ps
// checker module: predicts every sequencer step and compares it with the m_ transfers
module hps_status_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [hps_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [hps_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_wr_en,
    input  logic [hps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [hps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                               mismatch_count,
    output int                               outstanding
);
    import hps_pkg::*;

    // mirrored register file and sequencer state
    cfg_t       cfg;
    logic [3:0] seq_q;
    logic [1:0] fast_div;
    logic [7:0] sec_div;
    logic [15:0] step_cnt;
    logic [7:0] off_countdown;
    logic       pwr_on, pwr_boost, pwr_bypass, pwr_button;
    logic [2:0] up_reason;

    result_t    status_q[$];
    result_t    want;
    item_t      step_in;

    function automatic void power_up(input logic [2:0] why, input logic usb_ok);
        up_reason     = why;
        seq_q         = ST_NORMAL;
        off_countdown = 8'd0;
        step_cnt      = 16'd0;
        pwr_on        = 1'b1;
        if (usb_ok) begin
            pwr_bypass = 1'b1;
        end else begin
            pwr_boost = 1'b1;
        end
        sec_div = 8'(SEC_DIVIDE_DEF);
    endfunction

    // host button drive is deliberately left alone here
    function automatic void power_down();
        seq_q      = ST_SLEEP;
        pwr_on     = 1'b0;
        pwr_boost  = 1'b0;
        pwr_bypass = 1'b0;
    endfunction

    function automatic result_t sequencer_step(input item_t it);
        logic    fast, sec, beval, sleep_req;
        result_t r;
        fast      = 1'b0;
        sec       = 1'b0;
        beval     = 1'b0;
        sleep_req = 1'b0;

        // dividers advance first
        if (it.base_tick) begin
            fast_div = 2'((int'(fast_div) + 1) % FAST_DIVIDE_DEF);
            fast     = (fast_div == 2'd0);
            sec_div  = sec_div - 8'd1;
            if (sec_div == 8'd0) begin
                sec_div = 8'(SEC_DIVIDE_DEF);
                sec     = 1'b1;
            end
        end

        // countdown load happens in any state
        if (it.delay_write) begin
            off_countdown = it.delay_seconds;
        end

        case (seq_q)
            ST_WAKE_INIT: begin
                if (it.alarm_seen) begin
                    if (it.batt_low) begin
                        seq_q = ST_SLEEP;
                    end else begin
                        power_up(REASON_ALARM, it.usb_power_ok);
                    end
                end else if (it.button_held) begin
                    seq_q = it.batt_low ? ST_WAKE_WAIT_REL : ST_WAKE_WAIT_PRESS;
                end else if (!it.host_rail_prev && it.host_rail_good) begin
                    power_up(REASON_USB, it.usb_power_ok);
                end else if (cfg.restart_enable && it.batt_restart_ok) begin
                    power_up(REASON_RESTART, it.usb_power_ok);
                end else begin
                    seq_q = ST_SLEEP;
                end
            end
            ST_WAKE_WAIT_PRESS: begin
                if (fast) begin
                    beval = 1'b1;
                    if (it.button_held) begin
                        if (it.button_pressed) begin
                            power_up(REASON_BUTTON, it.usb_power_ok);
                        end
                    end else begin
                        seq_q = ST_SLEEP;
                    end
                end
                // alarm overrides a release seen in the same step
                if (it.alarm_seen) begin
                    power_up(REASON_ALARM, it.usb_power_ok);
                end
            end
            ST_WAKE_WAIT_REL, ST_NORMAL_WAIT_REL: begin
                if (fast) begin
                    beval = 1'b1;
                    if (!it.button_held) begin
                        seq_q = ST_SLEEP;
                    end
                end
            end
            ST_NORMAL: begin
                if (it.host_rail_prev && !it.host_rail_good) begin
                    power_down();
                end else if (fast) begin
                    beval = 1'b1;
                    if (it.button_pressed) begin
                        seq_q      = ST_SOFT_PULSE;
                        pwr_button = 1'b1;
                        step_cnt   = {8'd0, cfg.short_press_ticks};
                    end
                end
                // countdown expiry wins over a pulse started in this step
                if (sec && off_countdown != 8'd0) begin
                    off_countdown = off_countdown - 8'd1;
                    if (off_countdown == 8'd0) begin
                        power_down();
                    end
                end
            end
            ST_SOFT_PULSE: begin
                if (fast) begin
                    step_cnt = step_cnt - 16'd1;
                    if (step_cnt == 16'd0) begin
                        pwr_button = 1'b0;
                        seq_q      = ST_WAIT_HOST_OFF;
                        step_cnt   = cfg.host_off_timeout_s;
                    end
                end
            end
            ST_WAIT_HOST_OFF: begin
                if (sec) begin
                    step_cnt = step_cnt - 16'd1;
                end
                if (!it.host_rail_good) begin
                    power_down();
                    seq_q = ST_NORMAL_WAIT_REL;
                end else if (step_cnt == 16'd0) begin
                    pwr_button = 1'b1;
                    seq_q      = ST_HARD_OFF;
                    step_cnt   = {6'd0, cfg.hard_press_ticks};
                end
            end
            ST_HARD_OFF: begin
                if (fast) begin
                    step_cnt = step_cnt - 16'd1;
                    if (step_cnt == 16'd0) begin
                        pwr_button = 1'b0;
                        power_down();
                        seq_q = ST_NORMAL_WAIT_REL;
                    end
                end
            end
            ST_SLEEP: begin
                sleep_req = 1'b1;
                seq_q     = ST_WAKE_INIT;
                sec_div   = 8'(SEC_DIVIDE_DEF);
            end
            default: begin
                seq_q = ST_SLEEP;
            end
        endcase

        r.seq_state         = seq_q;
        r.power_on          = pwr_on;
        r.boost_on          = pwr_boost;
        r.bypass_on         = pwr_bypass;
        r.host_button_drive = pwr_button;
        r.power_up_reason   = up_reason;
        r.sleep_request     = sleep_req;
        r.fast_tick         = fast;
        r.sec_tick          = sec;
        r.button_eval       = beval;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg.restart_enable     = 1'b0;
            cfg.host_off_timeout_s = HOST_OFF_TMO_DEF;
            cfg.short_press_ticks  = SHORT_PRESS_DEF;
            cfg.hard_press_ticks   = HARD_PRESS_DEF;
            seq_q         = ST_WAKE_INIT;
            fast_div      = 2'd0;
            sec_div       = 8'(SEC_DIVIDE_DEF);
            step_cnt      = 16'd0;
            off_countdown = 8'd0;
            pwr_on        = 1'b0;
            pwr_boost     = 1'b0;
            pwr_bypass    = 1'b0;
            pwr_button    = 1'b0;
            up_reason     = REASON_NONE;
            mismatch_count = 0;
            status_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_RESTART_ENABLE: cfg.restart_enable     = cfg_wdata[0];
                    CFG_HOST_OFF_TMO:   cfg.host_off_timeout_s = cfg_wdata[15:0];
                    CFG_SHORT_PRESS:    cfg.short_press_ticks  = cfg_wdata[7:0];
                    CFG_HARD_PRESS:     cfg.hard_press_ticks   = cfg_wdata[9:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, expected none, actual 0x%h",
                             $time, m_tdata);
                    mismatch_count++;
                end else begin
                    want = status_q.pop_front();
                    check_field("seq_state",         want.seq_state,         m_tdata[3:0]);
                    check_field("power_on",          want.power_on,          m_tdata[4]);
                    check_field("boost_on",          want.boost_on,          m_tdata[5]);
                    check_field("bypass_on",         want.bypass_on,         m_tdata[6]);
                    check_field("host_button_drive", want.host_button_drive, m_tdata[7]);
                    check_field("power_up_reason",   want.power_up_reason,   m_tdata[10:8]);
                    check_field("sleep_request",     want.sleep_request,     m_tdata[11]);
                    check_field("fast_tick",         want.fast_tick,         m_tdata[12]);
                    check_field("sec_tick",          want.sec_tick,          m_tdata[13]);
                    check_field("button_eval",       want.button_eval,       m_tdata[14]);
                end
            end

            if (s_tvalid && s_tready) begin
                step_in.base_tick       = s_tdata[0];
                step_in.alarm_seen      = s_tdata[1];
                step_in.button_held     = s_tdata[2];
                step_in.button_pressed  = s_tdata[3];
                step_in.batt_low        = s_tdata[4];
                step_in.batt_restart_ok = s_tdata[5];
                step_in.host_rail_good  = s_tdata[6];
                step_in.host_rail_prev  = s_tdata[7];
                step_in.usb_power_ok    = s_tdata[8];
                step_in.delay_write     = s_tdata[9];
                step_in.delay_seconds   = s_tdata[17:10];
                status_q.push_back(sequencer_step(step_in));
            end
        end
        outstanding = status_q.size();
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// top of the host power sequencer testbench: clock, reset, step stimulus and verdict
module tb_top;
    import hps_pkg::*;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    // from bit 0: base_tick, alarm_seen, button_held, button_pressed, batt_low,
    // batt_restart_ok, host_rail_good, host_rail_prev, usb_power_ok, delay_write,
    // delay_seconds[7:0], zero fill
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    // from bit 0: seq_state[3:0], power_on, boost_on, bypass_on, host_button_drive,
    // power_up_reason[2:0], sleep_request, fast_tick, sec_tick, button_eval, zero fill
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    int mismatch_count;
    int outstanding;

    // percentages of cycles where the sender idles / the receiver stalls
    int send_gap_pct    = 0;
    int ready_stall_pct = 0;

    int items_sent    = 0;
    int ticks_sent    = 0;   // base ticks accepted, tracks the fast divider phase
    int session_count = 0;

    // register settings applied after the default phase: small values, a zero
    // host-off timeout (forces the hard press at once), then the upper extremes
    logic        restart_set[3] = '{1'b1, 1'b1, 1'b0};
    logic [15:0] tmo_set[3]     = '{16'd1, 16'd0, 16'd65535};
    logic [7:0]  short_set[3]   = '{8'd1, 8'd2, 8'd255};
    logic [9:0]  hard_set[3]    = '{10'd1, 10'd3, 10'd1023};

    host_power_sequencer_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    hps_status_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #5 aclk = ~aclk;

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // rail steady and good, nothing else going on
    function automatic item_t steady(input logic tick);
        item_t it;
        it                = '0;
        it.base_tick      = tick;
        it.host_rail_good = 1'b1;
        it.host_rail_prev = 1'b1;
        return it;
    endfunction

    // one step transfer, with random idle cycles ahead of it
    task automatic send_step(input item_t it);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, it.delay_seconds, it.delay_write, it.usb_power_ok,
                     it.host_rail_prev, it.host_rail_good, it.batt_restart_ok,
                     it.batt_low, it.button_pressed, it.button_held, it.alarm_seen,
                     it.base_tick};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (it.base_tick) begin
            ticks_sent++;
        end
    endtask

    // send hold steps with a base tick until the next one fires the fast tick,
    // which carries fin
    task automatic tick_until_fast(input item_t hold, input item_t fin);
        hold.base_tick = 1'b1;
        fin.base_tick  = 1'b1;
        while (((ticks_sent + 1) % FAST_DIVIDE_DEF) != 0) begin
            send_step(hold);
        end
        send_step(fin);
    endtask

    // stop sending and wait until every expected result has come back
    task automatic drain();
        int guard;
        s_tvalid <= 1'b0;
        guard = 0;
        @(posedge aclk);
        while (outstanding != 0 && guard < 50000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // random power sessions: mostly well-formed wake, run and shutdown sequences
    // with random content, plus some bursts of raw noise
    task automatic run_random();
        int    first, len, p_press, p_drop, p_dw;
        int    press_pct[3];
        int    drop_pct[3];
        logic  usb, rail_now, rail_last, held;
        item_t it, fin;
        press_pct = '{0, 2, 25};
        drop_pct  = '{0, 1, 5};
        first = items_sent;
        while (items_sent - first < 100) begin
            // rotate idling so gaps land on every part of a session
            case (session_count % 4)
                0: begin send_gap_pct = 0;  ready_stall_pct = 0;  end
                1: begin send_gap_pct = 88; ready_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  ready_stall_pct = 88; end
                default: begin send_gap_pct = 21; ready_stall_pct = 21; end
            endcase
            session_count++;
            usb = $urandom_range(1);

            if ($urandom_range(9) < 2) begin
                // raw noise, every field random
                repeat ($urandom_range(1, 12)) begin
                    it = 18'($urandom);
                    send_step(it);
                end
            end else begin
                // wake: each wake step is sent twice so it lands on wake-init
                // whether the block sits in wake-init or in sleep
                it = steady(1'b0);
                it.usb_power_ok = usb;
                case ($urandom_range(3))
                    0: it.alarm_seen = 1'b1;
                    1: it.host_rail_prev = 1'b0;
                    2: it.batt_restart_ok = 1'b1;
                    default: it.button_held = 1'b1;
                endcase
                send_step(it);
                send_step(it);
                if (it.button_held) begin
                    fin = it;
                    fin.button_pressed = 1'b1;
                    tick_until_fast(it, fin);
                end

                // running body with random events
                len     = ($urandom_range(4) == 0) ? $urandom_range(200, 300)
                                                   : $urandom_range(8, 60);
                p_press = press_pct[$urandom_range(2)];
                p_drop  = drop_pct[$urandom_range(2)];
                p_dw    = $urandom_range(1);
                rail_now = 1'b1;
                held     = 1'b0;
                repeat (len) begin
                    it = '0;
                    it.base_tick    = ($urandom_range(9) != 0);
                    it.usb_power_ok = usb;
                    rail_last = rail_now;
                    if (rail_now) begin
                        rail_now = !($urandom_range(99) < p_drop);
                    end else begin
                        rail_now = ($urandom_range(4) == 0);
                    end
                    it.host_rail_good = rail_now;
                    it.host_rail_prev = rail_last;
                    if ($urandom_range(99) < 4) begin
                        held = !held;
                    end
                    it.button_held     = held;
                    it.button_pressed  = ($urandom_range(99) < p_press);
                    it.alarm_seen      = ($urandom_range(99) == 0);
                    it.batt_low        = ($urandom_range(49) == 0);
                    it.batt_restart_ok = ($urandom_range(9) == 0);
                    if ($urandom_range(99) < p_dw) begin
                        it.delay_write   = 1'b1;
                        it.delay_seconds = ($urandom_range(3) == 0) ? 8'($urandom)
                                                                    : 8'($urandom_range(2));
                    end
                    send_step(it);
                end
            end
        end
    endtask

    initial begin
        item_t h, f, z;

        // reset held low at the start, never asserted again
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, register defaults ----
        send_gap_pct    = 21;
        ready_stall_pct = 21;
        z = '0;
        send_step(z);                        // nothing to wake for: go to sleep
        send_step(z);                        // sleep request, back to wake-init
        h = '1;
        send_step(h);                        // all fields high: alarm on low battery sleeps
        send_step(z);

        // button held on low battery, released on a fast tick
        h = '0;
        h.button_held = 1'b1;
        h.batt_low    = 1'b1;
        send_step(h);
        tick_until_fast(h, z);
        send_step(z);

        // alarm while waiting for a press, button released in that same step
        h = '0;
        h.button_held = 1'b1;
        send_step(h);
        f = '0;
        f.alarm_seen   = 1'b1;
        f.usb_power_ok = 1'b1;
        tick_until_fast(h, f);

        // host rail falling while running powers down
        h = steady(1'b0);
        h.host_rail_good = 1'b0;
        send_step(h);
        send_step(z);

        // host rail rising wakes on boost; a delayed power-down then gets canceled
        h = '0;
        h.host_rail_good = 1'b1;
        h.delay_write    = 1'b1;
        h.delay_seconds  = 8'hFF;
        send_step(h);
        h = steady(1'b0);
        h.delay_write = 1'b1;
        send_step(h);
        h = steady(1'b0);
        h.host_rail_good = 1'b0;
        send_step(h);
        send_step(z);

        // button wake, then soft shutdown pulse, then host drops its rail
        h = '0;
        h.button_held = 1'b1;
        send_step(h);
        f = h;
        f.button_pressed = 1'b1;
        tick_until_fast(h, f);
        f = steady(1'b0);
        f.button_pressed = 1'b1;
        tick_until_fast(steady(1'b0), f);
        repeat (int'(SHORT_PRESS_DEF)) tick_until_fast(steady(1'b0), steady(1'b0));
        h = '0;
        h.host_rail_prev = 1'b1;
        send_step(h);
        h.button_held = 1'b1;
        tick_until_fast(h, z);
        send_step(z);

        // countdown expiry in the very step that a button press starts the pulse:
        // align the fast divider, power up without a tick, then land the second
        // tick on a fast tick with the press
        while ((ticks_sent % FAST_DIVIDE_DEF) != 0) begin
            send_step(steady(1'b1));
        end
        h = steady(1'b0);
        h.alarm_seen = 1'b1;
        send_step(h);
        send_step(h);
        h = steady(1'b1);
        h.delay_write   = 1'b1;
        h.delay_seconds = 8'd1;
        send_step(h);
        repeat (SEC_DIVIDE_DEF - 2) send_step(steady(1'b1));
        h = steady(1'b1);
        h.button_pressed = 1'b1;
        send_step(h);
        send_step(z);

        // ---- random part, defaults first, then each register setting ----
        run_random();
        for (int p = 0; p < 3; p++) begin
            drain();
            write_reg(CFG_RESTART_ENABLE, {15'd0, restart_set[p]});
            write_reg(CFG_HOST_OFF_TMO,   tmo_set[p]);
            write_reg(CFG_SHORT_PRESS,    {8'd0, short_set[p]});
            write_reg(CFG_HARD_PRESS,     {6'd0, hard_set[p]});
            cfg_wr_en <= 1'b0;
            @(posedge aclk);
            run_random();
        end
        drain();
        repeat (10) @(posedge aclk);

        $display("covered %0d sequencer steps in %0d power sessions over four register settings,",
                 items_sent, session_count);
        $display("with idle-free, sender-idle, receiver-stall and mixed stretches");
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
